// ===== hw/rtl/hcbp_pkg.sv =====
// Shared constants, request codes and types of the Huffman code bit packer.
`default_nettype none

package hcbp_pkg;

    localparam int SYMBOL_COUNT    = 256;
    localparam int MAX_CODE_LENGTH = 32;

    localparam int SYM_W  = 8;
    localparam int LEN_W  = 6;
    localparam int WORD_W = 32;
    localparam int BYTE_W = 8;
    localparam int PEND_W = 7;
    localparam int CNT_W  = 3;
    localparam int NB_W   = 3;
    localparam int ACC_W  = WORD_W + PEND_W;
    localparam int ADDR_W = (SYMBOL_COUNT > 1) ? $clog2(SYMBOL_COUNT) : 1;

    localparam logic [SYM_W:0]   SYM_LIMIT = (SYM_W + 1)'(SYMBOL_COUNT);
    localparam logic [LEN_W-1:0] LEN_LIMIT = LEN_W'(MAX_CODE_LENGTH);

    localparam logic [1:0] REQ_ENCODE = 2'd0;
    localparam logic [1:0] REQ_LOAD   = 2'd1;
    localparam logic [1:0] REQ_FLUSH  = 2'd2;

    typedef struct packed {
        logic [LEN_W-1:0]  len;
        logic [WORD_W-1:0] word;
    } code_entry_t;

    localparam int ENTRY_W = $bits(code_entry_t);

    typedef struct packed {
        logic [NB_W-1:0]   nbytes;
        logic [WORD_W-1:0] bytes;
        logic [PEND_W-1:0] pend_bits;
        logic [CNT_W-1:0]  pend_cnt;
    } pack_result_t;

endpackage

`default_nettype wire

// ===== hw/rtl/hcbp_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module hcbp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                             aclk,
    input  wire logic                             wr_en,
    input  wire logic [$clog2(DEPTH)-1:0]         wr_addr,
    input  wire logic [WIDTH-1:0]                 wr_data,
    input  wire logic                             rd_en,
    input  wire logic [$clog2(DEPTH)-1:0]         rd_addr,
    output logic      [WIDTH-1:0]                 rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/hcbp_pack.sv =====
// Merge one request with the pending bits: bytes to emit and the new pending state.
`default_nettype none

module hcbp_pack import hcbp_pkg::*; (
    input  wire logic [1:0]        req_type,
    input  wire logic [LEN_W-1:0]  code_length,
    input  wire logic [WORD_W-1:0] code_word,
    input  wire logic [PEND_W-1:0] pend_bits,
    input  wire logic [CNT_W-1:0]  pend_cnt,
    output pack_result_t           result
);

    logic [ACC_W-1:0]  acc;
    logic [ACC_W-1:0]  rest;
    logic [LEN_W-1:0]  total;
    logic [NB_W-1:0]   enc_nbytes;

    // Code bits land just above the pending bits; bits above the total stay zero.
    assign acc        = ({{PEND_W{1'b0}}, code_word} << pend_cnt)
                        | {{WORD_W{1'b0}}, pend_bits};
    assign total      = LEN_W'(pend_cnt) + code_length;
    assign enc_nbytes = total[LEN_W-1:CNT_W];
    assign rest       = acc >> {enc_nbytes, 3'b000};

    always_comb begin
        result.nbytes    = '0;
        result.bytes     = '0;
        result.pend_bits = pend_bits;
        result.pend_cnt  = pend_cnt;
        unique case (req_type)
            REQ_ENCODE: begin
                if (code_length != '0) begin
                    result.nbytes    = enc_nbytes;
                    result.bytes     = acc[WORD_W-1:0];
                    result.pend_bits = rest[PEND_W-1:0];
                    result.pend_cnt  = total[CNT_W-1:0];
                end
            end
            REQ_FLUSH: begin
                result.nbytes    = (pend_cnt != '0) ? NB_W'(1) : '0;
                result.bytes     = {{(WORD_W - PEND_W){1'b0}}, pend_bits};
                result.pend_bits = '0;
                result.pend_cnt  = '0;
            end
            default: begin
                // Loads finish at acceptance; the unused code does nothing.
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== hw/rtl/huffman_code_bit_packer.sv =====
// Huffman code bit packer top level: code table, request stage and byte output buffer.
//
// Usage:
//   Requests enter on the s_ channel (valid/ready). A load writes one code table
//   entry; an encode appends the symbol's code bits, first bit lowest, to the bit
//   accumulator; a flush sends out a partial byte padded with zeros. Packed bytes
//   leave on the m_ channel; m_last_of_run marks the final byte of each request.
//   The first byte of a request is offered once the request has passed the request
//   stage and been loaded into the output byte buffer. Throughput: one request per
//   cycle while each request yields at most one byte and the receiver is ready.
//   An encode that yields k bytes (k up to 4) sends them from the output byte
//   buffer one byte per cycle while the receiver is ready; the next request
//   waits in the request stage and enters as the last byte leaves.
//   The code table lookup is a 256 x 38 RAM with registered read at transfer time.
//   Reset (aresetn low at a clock edge) clears the per-entry valid bits, so every
//   symbol reads as length zero, empties the accumulator and drops all queued
//   work. No clearing pass is needed: the block takes requests right after reset.
//   When the receiver stalls, the current byte holds, one request waits in the
//   request stage, and s_ready then drops.
`default_nettype none

module huffman_code_bit_packer import hcbp_pkg::*; (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire logic [1:0]        s_req_type,
    input  wire logic [SYM_W-1:0]  s_symbol,
    input  wire logic [LEN_W-1:0]  s_code_length,
    input  wire logic [WORD_W-1:0] s_code_word,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output logic [BYTE_W-1:0]      m_out_byte,
    output logic                   m_last_of_run
);

    // Input side: transfer, table write and lookup
    logic                    s_fire;
    logic                    sym_in_range;
    logic [ADDR_W-1:0]       sym_addr;
    logic [LEN_W-1:0]        load_len;
    logic [WORD_W-1:0]       load_word;
    code_entry_t             load_entry;
    code_entry_t             rd_entry;
    logic                    tbl_wr_en;

    logic [SYMBOL_COUNT-1:0] entry_valid_reg;
    logic [SYMBOL_COUNT-1:0] entry_valid_next;

    // Request stage
    logic                    rq_valid_reg;
    logic                    rq_valid_next;
    logic [1:0]              rq_type_reg;
    logic                    rq_hit_reg;
    logic                    rq_fire;
    logic [LEN_W-1:0]        rq_len;

    // Accumulator
    logic [PEND_W-1:0]       pend_bits_reg;
    logic [PEND_W-1:0]       pend_bits_next;
    logic [CNT_W-1:0]        pend_cnt_reg;
    logic [CNT_W-1:0]        pend_cnt_next;
    pack_result_t            pack;

    // Output byte buffer
    logic [WORD_W-1:0]       obuf_reg;
    logic [WORD_W-1:0]       obuf_next;
    logic [NB_W-1:0]         oleft_reg;
    logic [NB_W-1:0]         oleft_next;
    logic                    m_fire;
    logic                    obuf_free;

    assign s_fire       = s_valid && s_ready;
    assign sym_in_range = {1'b0, s_symbol} < SYM_LIMIT;
    assign sym_addr     = s_symbol[ADDR_W-1:0];

    // Saturate the length and drop stray code bits above it before the write.
    assign load_len = (s_code_length > LEN_LIMIT) ? LEN_LIMIT : s_code_length;

    always_comb begin
        for (int i = 0; i < WORD_W; i++) begin
            load_word[i] = s_code_word[i] && (LEN_W'(i) < load_len);
        end
    end

    assign load_entry.len  = load_len;
    assign load_entry.word = load_word;
    assign tbl_wr_en       = s_fire && (s_req_type == REQ_LOAD) && sym_in_range;

    // Read at transfer time; hold the read data while the request stage stalls.
    hcbp_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (SYMBOL_COUNT)
    ) u_code_table (
        .aclk    (aclk),
        .wr_en   (tbl_wr_en),
        .wr_addr (sym_addr),
        .wr_data (load_entry),
        .rd_en   (s_fire),
        .rd_addr (sym_addr),
        .rd_data (rd_entry)
    );

    always_comb begin
        entry_valid_next = entry_valid_reg;
        if (tbl_wr_en) begin
            entry_valid_next[sym_addr] = 1'b1;
        end
    end

    // The output buffer can take a new request's bytes once its last byte leaves.
    assign m_fire    = m_valid && m_ready;
    assign obuf_free = (oleft_reg == '0) || ((oleft_reg == NB_W'(1)) && m_ready);
    assign rq_fire   = rq_valid_reg && obuf_free;
    assign s_ready   = !rq_valid_reg || rq_fire;

    // A never-loaded or out-of-range symbol reads as length zero.
    assign rq_len = rq_hit_reg ? rd_entry.len : '0;

    hcbp_pack u_pack (
        .req_type    (rq_type_reg),
        .code_length (rq_len),
        .code_word   (rd_entry.word),
        .pend_bits   (pend_bits_reg),
        .pend_cnt    (pend_cnt_reg),
        .result      (pack)
    );

    always_comb begin
        rq_valid_next  = rq_valid_reg;
        pend_bits_next = pend_bits_reg;
        pend_cnt_next  = pend_cnt_reg;
        obuf_next      = obuf_reg;
        oleft_next     = oleft_reg;

        if (rq_fire) begin
            rq_valid_next = 1'b0;
        end
        if (s_fire) begin
            rq_valid_next = 1'b1;
        end

        // Advance the buffer one byte per transfer; reload when a request enters.
        if (m_fire) begin
            obuf_next  = obuf_reg >> BYTE_W;
            oleft_next = oleft_reg - NB_W'(1);
        end
        if (rq_fire) begin
            obuf_next      = pack.bytes;
            oleft_next     = pack.nbytes;
            pend_bits_next = pack.pend_bits;
            pend_cnt_next  = pack.pend_cnt;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            entry_valid_reg <= '0;
            rq_valid_reg    <= 1'b0;
            pend_bits_reg   <= '0;
            pend_cnt_reg    <= '0;
            oleft_reg       <= '0;
        end else begin
            entry_valid_reg <= entry_valid_next;
            rq_valid_reg    <= rq_valid_next;
            pend_bits_reg   <= pend_bits_next;
            pend_cnt_reg    <= pend_cnt_next;
            oleft_reg       <= oleft_next;
        end
    end

    // Payload registers: no reset.
    always_ff @(posedge aclk) begin
        obuf_reg <= obuf_next;
        if (s_fire) begin
            rq_type_reg <= s_req_type;
            rq_hit_reg  <= sym_in_range && entry_valid_reg[sym_addr];
        end
    end

    assign m_valid       = (oleft_reg != '0);
    assign m_out_byte    = obuf_reg[BYTE_W-1:0];
    assign m_last_of_run = (oleft_reg == NB_W'(1));

`ifndef SYNTH
    // No request ever yields more bytes than the buffer holds.
    a_nbytes_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        rq_fire |-> (pack.nbytes <= NB_W'(4)))
        else $error("request yields more than four bytes");

    // Pending bits above the pending count stay clear.
    a_pend_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        ((pend_bits_reg >> pend_cnt_reg) == '0))
        else $error("stray bits above pending count");

    // A flush leaves the accumulator empty.
    a_flush_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (rq_fire && (rq_type_reg == REQ_FLUSH)) |=> (pend_cnt_reg == '0))
        else $error("accumulator not empty after flush");

    // A request can only be refused while one waits in the request stage.
    a_ready_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (rq_valid_reg && !obuf_free))
        else $error("input stalled without a waiting request");
`endif

endmodule

`default_nettype wire

// ===== tb/tb_top.sv =====
// Self-checking testbench for the Huffman code bit packer: table loads, encodes, flushes.
`default_nettype none

module tb_top import hcbp_pkg::*; ();

    // The one request code the package leaves unnamed; the block must ignore it.
    localparam logic [1:0] REQ_UNUSED = 2'd3;
    // Generous ceiling, far above the slowest legal run of this sequence.
    localparam int CYCLE_LIMIT = 200000;

    typedef struct {
        logic [BYTE_W-1:0] data;
        logic              last;
    } out_rec_t;

    logic              aclk          = 1'b0;
    logic              aresetn       = 1'b0;
    logic              s_valid       = 1'b0;
    logic              s_ready;
    logic [1:0]        s_req_type    = REQ_ENCODE;
    logic [SYM_W-1:0]  s_symbol      = '0;
    logic [LEN_W-1:0]  s_code_length = '0;
    logic [WORD_W-1:0] s_code_word   = '0;
    logic              m_valid;
    logic              m_ready       = 1'b0;
    logic [BYTE_W-1:0] m_out_byte;
    logic              m_last_of_run;

    // Shadow copy of the block's state: code table and bit accumulator.
    logic [LEN_W-1:0]  tbl_len  [SYMBOL_COUNT];
    logic [WORD_W-1:0] tbl_word [SYMBOL_COUNT];
    logic [PEND_W-1:0] acc_bits;
    logic [CNT_W-1:0]  acc_cnt;

    // Bytes the block owes us, oldest first.
    out_rec_t outgoing_bytes [$];
    out_rec_t head_rec;

    int mismatch_count = 0;
    int cycle_count    = 0;

    // Idle controls: random bursts on each side, plus one long receiver hold-off.
    bit tx_bursts    = 1'b0;
    bit rx_bursts    = 1'b0;
    int rx_gap_left  = 0;
    int rx_hold_left = 0;

    huffman_code_bit_packer dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_req_type    (s_req_type),
        .s_symbol      (s_symbol),
        .s_code_length (s_code_length),
        .s_code_word   (s_code_word),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_out_byte    (m_out_byte),
        .m_last_of_run (m_last_of_run)
    );

    always #10 aclk = ~aclk;

    // Abort the run if the cycle budget runs out; a hang counts as a failure.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles", cycle_count);
            $display("Mismatches found");
            $finish;
        end
    end

    // Receiver: a long hold-off takes priority, then random stall bursts,
    // otherwise accept every cycle.
    always @(posedge aclk) begin
        if (rx_hold_left > 0) begin
            m_ready <= 1'b0;
            rx_hold_left--;
        end else if (rx_gap_left > 0) begin
            m_ready <= 1'b0;
            rx_gap_left--;
        end else if (rx_bursts && $urandom_range(0, 5) == 0) begin
            rx_gap_left = $urandom_range(1, 18) - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    task automatic report_mismatch(input string what, input logic [BYTE_W-1:0] got,
                                   input logic [BYTE_W-1:0] want);
        mismatch_count++;
        $display("[%0t] %s: got 'h%02h, want 'h%02h", $time, what, got, want);
    endtask

    // Compare every output transfer against the oldest owed byte.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (outgoing_bytes.size() == 0) begin
                report_mismatch("byte with nothing owed", m_out_byte, '0);
            end else begin
                head_rec = outgoing_bytes.pop_front();
                if (m_out_byte !== head_rec.data)
                    report_mismatch("out_byte", m_out_byte, head_rec.data);
                if (m_last_of_run !== head_rec.last)
                    report_mismatch("last_of_run", BYTE_W'(m_last_of_run),
                                    BYTE_W'(head_rec.last));
            end
        end
    end

    // Predict the bytes one accepted request produces and advance the shadow state.
    function automatic void pack_request(input logic [1:0] req, input logic [SYM_W-1:0] sym,
                                         input logic [LEN_W-1:0] len,
                                         input logic [WORD_W-1:0] word);
        logic [63:0]      acc;
        logic [LEN_W-1:0] eff_len;
        int               cnt;
        out_rec_t         rec;
        case (req)
            REQ_LOAD: begin
                if (int'(sym) < SYMBOL_COUNT) begin
                    // Saturate overlong lengths, drop code bits past the length.
                    eff_len = (len > LEN_LIMIT) ? LEN_LIMIT : len;
                    tbl_len[sym]  = eff_len;
                    tbl_word[sym] = (eff_len >= LEN_W'(WORD_W)) ? word
                                  : word & ((WORD_W'(1) << eff_len) - 1'b1);
                end
            end
            REQ_FLUSH: begin
                // An empty accumulator flushes to nothing.
                if (acc_cnt != 0) begin
                    rec.data = BYTE_W'(acc_bits);
                    rec.last = 1'b1;
                    outgoing_bytes.push_back(rec);
                end
                acc_bits = '0;
                acc_cnt  = '0;
            end
            REQ_ENCODE: begin
                // A never-loaded or cleared symbol has length zero and adds no bits.
                if (int'(sym) < SYMBOL_COUNT && tbl_len[sym] != 0) begin
                    acc = 64'(acc_bits) | (64'(tbl_word[sym]) << acc_cnt);
                    cnt = int'(acc_cnt) + int'(tbl_len[sym]);
                    while (cnt >= 8) begin
                        rec.data = acc[7:0];
                        rec.last = (cnt < 16);
                        outgoing_bytes.push_back(rec);
                        acc = acc >> 8;
                        cnt -= 8;
                    end
                    acc_bits = acc[PEND_W-1:0];
                    acc_cnt  = CNT_W'(cnt);
                end
            end
            default: ;
        endcase
    endfunction

    // Offer one request and hold it until the transfer; then maybe idle a burst.
    // Valid stays high when no gap follows, so back-to-back requests never dip.
    task automatic send_req(input logic [1:0] req, input logic [SYM_W-1:0] sym,
                            input logic [LEN_W-1:0] len, input logic [WORD_W-1:0] word);
        int gap;
        s_valid       <= 1'b1;
        s_req_type    <= req;
        s_symbol      <= sym;
        s_code_length <= len;
        s_code_word   <= word;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        pack_request(req, sym, len, word);
        if (tx_bursts && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 18);
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    // Drop valid, wait for every owed byte, then let the pipeline settle.
    task automatic wait_drained();
        s_valid <= 1'b0;
        while (outgoing_bytes.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    // Mostly encodes of a small, loaded symbol pool with random content; the
    // rest are loads, flushes and the unused request code.
    task automatic send_random_request();
        int                pick;
        logic [1:0]        req;
        logic [SYM_W-1:0]  sym;
        logic [LEN_W-1:0]  len;
        logic [WORD_W-1:0] word;
        pick = $urandom_range(0, 99);
        word = $urandom();
        sym  = ($urandom_range(0, 9) < 8) ? SYM_W'($urandom_range(0, 15))
                                          : SYM_W'($urandom_range(0, SYMBOL_COUNT - 1));
        len  = ($urandom_range(0, 9) < 8) ? LEN_W'($urandom_range(1, 16))
                                          : LEN_W'($urandom_range(0, 63));
        if (pick < 15)      req = REQ_LOAD;
        else if (pick < 85) req = REQ_ENCODE;
        else if (pick < 95) req = REQ_FLUSH;
        else                req = REQ_UNUSED;
        send_req(req, sym, len, word);
    endtask

    // Right after reset the table is empty: nothing may come out.
    task automatic test_empty_table();
        send_req(REQ_ENCODE, 8'd0, '0, '0);
        send_req(REQ_ENCODE, 8'd255, '0, '0);
        send_req(REQ_FLUSH, '0, '0, '0);
        send_req(REQ_UNUSED, '1, '1, '1);
        wait_drained();
    endtask

    // Field extremes, saturation, stray bits, empty codes and empty flushes.
    task automatic test_directed_codes();
        send_req(REQ_LOAD, 8'd0, 6'd1, 32'h0000_0001);
        send_req(REQ_LOAD, 8'd255, 6'd32, 32'hFFFF_FFFF);
        send_req(REQ_LOAD, 8'd3, 6'd5, 32'hFFFF_FFE3);   // stray bits above length
        send_req(REQ_LOAD, 8'd1, 6'd40, 32'hA5A5_A5A5);  // overlong, saturates
        send_req(REQ_LOAD, 8'd2, 6'd63, 32'h5A5A_5A5A);  // all length bits set
        send_req(REQ_LOAD, 8'd4, 6'd8, 32'h0000_0096);
        send_req(REQ_LOAD, 8'd5, 6'd0, 32'hFFFF_FFFF);   // no code
        send_req(REQ_ENCODE, 8'd0, '0, '0);
        send_req(REQ_ENCODE, 8'd255, '0, '0);            // four bytes at once
        send_req(REQ_ENCODE, 8'd3, '0, '0);
        send_req(REQ_ENCODE, 8'd1, '0, '0);
        send_req(REQ_ENCODE, 8'd2, '0, '0);
        send_req(REQ_ENCODE, 8'd5, '0, '0);
        send_req(REQ_ENCODE, 8'd4, '0, '0);
        send_req(REQ_UNUSED, '0, '0, '0);
        send_req(REQ_FLUSH, '0, '0, '0);
        send_req(REQ_FLUSH, '0, '0, '0);                 // nothing pending
        send_req(REQ_LOAD, 8'd0, 6'd0, 32'h0000_0001);   // clear an entry
        send_req(REQ_ENCODE, 8'd0, '0, '0);
        send_req(REQ_ENCODE, 8'd4, '0, '0);              // aligned, exactly one byte
        wait_drained();
    endtask

    // Load the pool, then random traffic with idling on both sides.
    task automatic test_random_traffic();
        for (int i = 0; i < 16; i++)
            send_req(REQ_LOAD, SYM_W'(i), LEN_W'($urandom_range(1, 32)), $urandom());
        for (int i = 0; i < 50; i++)
            send_random_request();
        wait_drained();
    endtask

    // Hold the receiver off for a long stretch while the sender keeps offering
    // long codes, so the output fills and the input stalls.
    task automatic test_backpressure();
        send_req(REQ_LOAD, 8'd20, 6'd32, $urandom());
        send_req(REQ_LOAD, 8'd21, 6'd13, $urandom());
        tx_bursts    = 1'b0;
        rx_bursts    = 1'b0;
        rx_hold_left = 300;
        for (int i = 0; i < 10; i++)
            send_req(REQ_ENCODE, (i % 3 == 2) ? 8'd21 : 8'd20, '0, '0);
        send_req(REQ_FLUSH, '0, '0, '0);
        wait_drained();
    endtask

    // Close with full-rate traffic: no idling on either side.
    task automatic test_steady_stream();
        tx_bursts = 1'b0;
        rx_bursts = 1'b0;
        for (int i = 0; i < 20; i++)
            send_random_request();
        send_req(REQ_FLUSH, '0, '0, '0);
        wait_drained();
    endtask

    initial begin
        for (int i = 0; i < SYMBOL_COUNT; i++) begin
            tbl_len[i]  = '0;
            tbl_word[i] = '0;
        end
        acc_bits = '0;
        acc_cnt  = '0;

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        tx_bursts = 1'b1;
        rx_bursts = 1'b1;
        test_empty_table();
        test_directed_codes();
        test_random_traffic();
        test_backpressure();
        test_steady_stream();

        if (mismatch_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

`default_nettype wire
